### hw/rtl/rrts_pkg.sv
// ============================================================================
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Transaction payloads, operation codes and the reset-time slot constants.
// ============================================================================
`default_nettype none

package rrts_pkg;

    // Operation codes carried in a command transaction
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_READY   = 2'd1,
        FUNC_QUANTUM = 2'd2,
        FUNC_LEAVE   = 2'd3
    } func_t;

    // Slot 0 is the idle task
    localparam int unsigned IDLE_SLOT    = 0;
    // Slot that runs out of reset, and its quantum at reset
    localparam int unsigned BOOT_SLOT    = 1;
    localparam int unsigned BOOT_QUANTUM = 2;

    typedef struct packed {
        func_t       func;
        logic [3:0]  task_id;
        logic [15:0] quantum_value;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  running_task;
        logic        switched;
        logic [15:0] slice_left;
        logic [4:0]  ready_count;
        logic [31:0] elapsed_ticks;
        logic [31:0] dispatch_count;
        logic        error;
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/rrts_ready_queue.sv
// ============================================================================
// rrts_ready_queue: ring of ready task slots
// Single-port style ring memory with head, tail and fill level; a pop
// returns the head entry through a register, in the cycle after the pop.
// ============================================================================
`default_nettype none

module rrts_ready_queue #(
    parameter int unsigned TASK_SLOTS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    input  wire logic [$clog2(TASK_SLOTS)-1:0]         push_slot,
    input  wire logic                                  pop,
    output logic      [$clog2(TASK_SLOTS)-1:0]         pop_slot,
    output logic      [$clog2(TASK_SLOTS+1)-1:0]       level
);
    import rrts_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
    localparam int unsigned LVL_W  = $clog2(TASK_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(TASK_SLOTS - 1);

    logic [SLOT_W-1:0] ring_mem [TASK_SLOTS];
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] tail_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [SLOT_W-1:0] pop_slot_reg;

    function automatic logic [SLOT_W-1:0] next_pos(input logic [SLOT_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + SLOT_W'(1);
    endfunction

    // storage and registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[tail_reg] <= push_slot;
        end
        if (pop)
        begin
            pop_slot_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= next_pos(tail_reg);
            end
            if (pop)
            begin
                head_reg <= next_pos(head_reg);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

    assign pop_slot = pop_slot_reg;
    assign level    = level_reg;

`ifndef SYNTHESIS
    // occupancy never goes past the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(TASK_SLOTS))
        else $error("ready queue level above capacity");
    // pop only with something queued
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("pop from empty ready queue");
    // push only with room left
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (level_reg < LVL_W'(TASK_SLOTS)))
        else $error("push into full ready queue");
`endif

endmodule

`default_nettype wire

### hw/rtl/rrts_task_table.sv
// ============================================================================
// rrts_task_table: per-slot quantum, elapsed-tick and dispatch-count memory
// One write and one registered read per cycle; rows never written read
// back as their reset contents through per-row valid bits.
// ============================================================================
`default_nettype none

module rrts_task_table #(
    parameter int unsigned TASK_SLOTS   = 16,
    parameter int unsigned QUANTUM_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(TASK_SLOTS)-1:0]     rd_addr,
    output logic      [QUANTUM_BITS-1:0]           rd_quantum,
    output logic      [31:0]                       rd_elapsed,
    output logic      [31:0]                       rd_count,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(TASK_SLOTS)-1:0]     wr_addr,
    input  wire logic [QUANTUM_BITS-1:0]           wr_quantum,
    input  wire logic [31:0]                       wr_elapsed,
    input  wire logic [31:0]                       wr_count
);
    import rrts_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
    localparam int unsigned ROW_W  = QUANTUM_BITS + 64;

    logic [ROW_W-1:0]  row_mem [TASK_SLOTS];
    logic [ROW_W-1:0]  rd_row_reg;
    logic [TASK_SLOTS-1:0] valid_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= {wr_quantum, wr_elapsed, wr_count};
        end
        if (rd_en)
        begin
            rd_row_reg  <= row_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten rows: boot slot has its reset quantum, all else zero
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_quantum = rd_row_reg[ROW_W-1:64];
            rd_elapsed = rd_row_reg[63:32];
            rd_count   = rd_row_reg[31:0];
        end
        else
        begin
            rd_quantum = (rd_addr_reg == SLOT_W'(BOOT_SLOT)) ?
                         QUANTUM_BITS'(BOOT_QUANTUM) : '0;
            rd_elapsed = '0;
            rd_count   = '0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/round_robin_task_scheduler_core.sv
// ============================================================================
// round_robin_task_scheduler_core: round-robin time-slice task scheduler
// Sequencer, running-task row cache and output register around the task
// table and ready queue memories.
// ============================================================================
`default_nettype none

// One command transaction in, one status transaction out. Slot 0 is the idle
// task; slot 1 runs out of reset with a quantum of 2. A command passes through
// accept, execute and result states for a tick without dispatch, a make-ready
// or a set-quantum of the running task; a set-quantum of any other slot adds a
// read-modify-write of its task-table row, and a tick that dispatches or a
// leave adds a write-back of the outgoing row, a pop of the ready queue and a
// read of the incoming row. The task table and the ready queue both have
// registered reads. A new command is taken while the previous status still
// waits in the output register; the result of the next one is held until
// that register is free. The running task's row lives in a register cache
// and is written to the table only when the task is switched out.
module round_robin_task_scheduler_core #(
    parameter int unsigned TASK_SLOTS   = 16,
    parameter int unsigned QUANTUM_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire rrts_pkg::cmd_t cmd,
    output logic                status_valid,
    input  wire logic           status_ready,
    output rrts_pkg::status_t   status
);
    import rrts_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
    localparam int unsigned LVL_W  = $clog2(TASK_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_LOAD,
        S_QWR,
        S_FIN
    } state_t;

    state_t            state_reg;

    // latched command
    func_t             op_func_reg;
    logic [3:0]        op_tid_reg;
    logic [15:0]       op_qv_reg;

    // scheduler state
    logic [SLOT_W-1:0]       cur_reg;
    logic [QUANTUM_BITS-1:0] remaining_reg;
    logic                    pop_reg;      // next slot comes from the queue
    logic                    requeue_reg;  // outgoing task goes to the tail
    logic                    switched_reg;
    logic                    err_reg;

    // cached row of the running task (table copy is stale while it runs)
    logic [QUANTUM_BITS-1:0] cache_quantum_reg;
    logic [31:0]             cache_elapsed_reg;
    logic [31:0]             cache_count_reg;

    status_t           status_reg;
    logic              status_valid_reg;

    // memory ports
    logic                    tbl_rd_en;
    logic [SLOT_W-1:0]       tbl_rd_addr;
    logic [QUANTUM_BITS-1:0] tbl_rd_quantum;
    logic [31:0]             tbl_rd_elapsed;
    logic [31:0]             tbl_rd_count;
    logic                    tbl_wr_en;
    logic [SLOT_W-1:0]       tbl_wr_addr;
    logic [QUANTUM_BITS-1:0] tbl_wr_quantum;
    logic [31:0]             tbl_wr_elapsed;
    logic [31:0]             tbl_wr_count;

    logic                    q_push;
    logic [SLOT_W-1:0]       q_push_slot;
    logic                    q_pop;
    logic [SLOT_W-1:0]       q_pop_slot;
    logic [LVL_W-1:0]        q_level;

    // decode helpers
    logic [31:0]             tick_elapsed;
    logic [QUANTUM_BITS-1:0] slice_dec;
    logic                    tick_switch;
    logic                    queue_nonempty;
    logic [SLOT_W-1:0]       tid_slot;
    logic                    tid_in_range;
    logic                    ready_err;
    logic [SLOT_W-1:0]       next_slot;

    rrts_task_table #(
        .TASK_SLOTS   (TASK_SLOTS),
        .QUANTUM_BITS (QUANTUM_BITS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (tbl_rd_en),
        .rd_addr    (tbl_rd_addr),
        .rd_quantum (tbl_rd_quantum),
        .rd_elapsed (tbl_rd_elapsed),
        .rd_count   (tbl_rd_count),
        .wr_en      (tbl_wr_en),
        .wr_addr    (tbl_wr_addr),
        .wr_quantum (tbl_wr_quantum),
        .wr_elapsed (tbl_wr_elapsed),
        .wr_count   (tbl_wr_count)
    );

    rrts_ready_queue #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_slot (q_push_slot),
        .pop       (q_pop),
        .pop_slot  (q_pop_slot),
        .level     (q_level)
    );

    assign tick_elapsed   = cache_elapsed_reg + 32'd1;
    // slice counts down and sticks at zero
    assign slice_dec      = (remaining_reg != '0) ?
                            remaining_reg - QUANTUM_BITS'(1) : remaining_reg;
    assign queue_nonempty = (q_level != '0);
    assign tick_switch    = (slice_dec == '0) && queue_nonempty;
    assign tid_in_range   = (32'(op_tid_reg) < TASK_SLOTS);
    assign tid_slot       = SLOT_W'(op_tid_reg);
    // idle slot, slot beyond the table, or no room left
    assign ready_err      = (op_tid_reg == 4'(IDLE_SLOT)) || !tid_in_range ||
                            (q_level >= LVL_W'(TASK_SLOTS));
    // leave with an empty queue falls back to idle
    assign next_slot      = pop_reg ? q_pop_slot : SLOT_W'(IDLE_SLOT);

    // memory port control
    always_comb
    begin
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = cur_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = cur_reg;
        tbl_wr_quantum = cache_quantum_reg;
        tbl_wr_elapsed = cache_elapsed_reg;
        tbl_wr_count   = cache_count_reg;
        q_push         = 1'b0;
        q_push_slot    = cur_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                case (op_func_reg)
                    FUNC_TICK:
                    begin
                        // switching out: write back row, start the pop
                        if (tick_switch)
                        begin
                            q_pop          = 1'b1;
                            tbl_wr_en      = 1'b1;
                            tbl_wr_elapsed = tick_elapsed;
                        end
                    end
                    FUNC_READY:
                    begin
                        if (!ready_err)
                        begin
                            q_push      = 1'b1;
                            q_push_slot = tid_slot;
                        end
                    end
                    FUNC_QUANTUM:
                    begin
                        if (tid_in_range && (tid_slot != cur_reg))
                        begin
                            tbl_rd_en   = 1'b1;
                            tbl_rd_addr = tid_slot;
                        end
                    end
                    default:
                    begin
                        q_pop     = queue_nonempty;
                        tbl_wr_en = 1'b1;
                    end
                endcase
            end
            S_POP:
            begin
                // row written last cycle, so a re-dispatch of the same slot
                // reads the fresh copy
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = next_slot;
                q_push      = requeue_reg;
            end
            S_QWR:
            begin
                tbl_wr_en      = 1'b1;
                tbl_wr_addr    = tid_slot;
                tbl_wr_quantum = QUANTUM_BITS'(op_qv_reg);
                tbl_wr_elapsed = tbl_rd_elapsed;
                tbl_wr_count   = tbl_rd_count;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, scheduler state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_func_reg       <= FUNC_TICK;
            op_tid_reg        <= '0;
            op_qv_reg         <= '0;
            cur_reg           <= SLOT_W'(BOOT_SLOT);
            remaining_reg     <= '0;
            pop_reg           <= 1'b0;
            requeue_reg       <= 1'b0;
            switched_reg      <= 1'b0;
            err_reg           <= 1'b0;
            cache_quantum_reg <= QUANTUM_BITS'(BOOT_QUANTUM);
            cache_elapsed_reg <= '0;
            cache_count_reg   <= '0;
            status_reg        <= '0;
            status_valid_reg  <= 1'b0;
        end
        else
        begin
            // the result state reloads the register itself
            if (status_valid_reg && status_ready && (state_reg != S_FIN))
            begin
                status_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_func_reg <= cmd.func;
                        op_tid_reg  <= cmd.task_id;
                        op_qv_reg   <= cmd.quantum_value;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    switched_reg <= 1'b0;
                    err_reg      <= 1'b0;
                    case (op_func_reg)
                        FUNC_TICK:
                        begin
                            cache_elapsed_reg <= tick_elapsed;
                            remaining_reg     <= slice_dec;
                            if (tick_switch)
                            begin
                                pop_reg     <= 1'b1;
                                requeue_reg <= (cur_reg != SLOT_W'(IDLE_SLOT));
                                state_reg   <= S_POP;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        FUNC_READY:
                        begin
                            err_reg   <= ready_err;
                            state_reg <= S_FIN;
                        end
                        FUNC_QUANTUM:
                        begin
                            if (tid_in_range && (tid_slot != cur_reg))
                            begin
                                state_reg <= S_QWR;
                            end
                            else
                            begin
                                if (tid_in_range)
                                begin
                                    cache_quantum_reg <= QUANTUM_BITS'(op_qv_reg);
                                end
                                state_reg <= S_FIN;
                            end
                        end
                        default:
                        begin
                            pop_reg     <= queue_nonempty;
                            requeue_reg <= 1'b0;
                            state_reg   <= S_POP;
                        end
                    endcase
                end
                S_POP:
                begin
                    cur_reg   <= next_slot;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    cache_quantum_reg <= tbl_rd_quantum;
                    cache_elapsed_reg <= tbl_rd_elapsed;
                    cache_count_reg   <= tbl_rd_count + 32'd1;
                    remaining_reg     <= tbl_rd_quantum;
                    switched_reg      <= 1'b1;
                    state_reg         <= S_FIN;
                end
                S_QWR:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!status_valid_reg || status_ready)
                    begin
                        status_reg.running_task   <= 4'(cur_reg);
                        status_reg.switched       <= switched_reg;
                        status_reg.slice_left     <= 16'(remaining_reg);
                        status_reg.ready_count    <= 5'(q_level);
                        status_reg.elapsed_ticks  <= cache_elapsed_reg;
                        status_reg.dispatch_count <= cache_count_reg;
                        status_reg.error          <= err_reg;
                        status_valid_reg          <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready    = (state_reg == S_IDLE);
    assign status_valid = status_valid_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    // running slot always names a real table row
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) < TASK_SLOTS)
        else $error("running slot out of range");
    // a new status appears only from the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("status loaded outside result state");
    // the running task changes only through a dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg != $past(cur_reg)) |-> $past(state_reg == S_POP))
        else $error("running task changed without dispatch");
    // the table is never read and written at the same row in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_rd_en && tbl_wr_en) |-> (tbl_rd_addr != tbl_wr_addr))
        else $error("task table read and write collide");
`endif

endmodule

`default_nettype wire

### test/tb_round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_round_robin_task_scheduler_core: self-checking bench for the scheduler
// Drives command transactions through a short directed table and a random
// stream, checking every status against a golden value or a cycle-free
// scheduler predictor under several sender-idle and receiver-stall mixes.
// ============================================================================

module tb_round_robin_task_scheduler_core;

    import rrts_pkg::*;

    localparam int unsigned SLOTS        = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 100;   // per idling phase
    localparam int unsigned MAX_GAP      = 40;
    localparam int unsigned DRAIN_CYCLES = 10;

    // One row of the directed table. Rows with typed set carry a golden
    // status; the others are checked against the predictor.
    typedef struct {
        cmd_t    cmd;
        bit      typed;
        status_t golden;
    } dir_row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    cmd_valid    = 1'b0;
    logic    cmd_ready;
    cmd_t    cmd          = '0;
    logic    status_valid;
    logic    status_ready = 1'b0;
    status_t status;

    // Idling knobs, in percent per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    status_t  pending_status_q[$];
    dir_row_t dir_rows[$];

    // ------------------------------------------------------------------
    // Scheduler predictor state: ready queue ring, running task, per-slot
    // quantum, elapsed ticks and dispatch counts.
    // ------------------------------------------------------------------
    logic [3:0]  rq_slot [SLOTS];
    logic [3:0]  rq_head = '0;
    logic [3:0]  rq_tail = '0;
    logic [4:0]  rq_level = '0;
    logic [3:0]  run_slot = 4'(BOOT_SLOT);
    logic [15:0] run_slice = '0;
    logic [15:0] quantum_of [SLOTS];
    logic [31:0] elapsed_of [SLOTS];
    logic [31:0] dispatches_of [SLOTS];

    round_robin_task_scheduler_core #(
        .TASK_SLOTS   (SLOTS),
        .QUANTUM_BITS (16)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: status_ready is redrawn every cycle from the stall percentage
    always @(posedge clk)
    begin
        status_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    function automatic void rq_push(logic [3:0] slot);
        rq_slot[rq_tail] = slot;
        rq_tail          = rq_tail + 1'b1;
        rq_level         = rq_level + 1'b1;
    endfunction

    function automatic logic [3:0] rq_pop();
        logic [3:0] slot;
        slot     = rq_slot[rq_head];
        rq_head  = rq_head + 1'b1;
        rq_level = rq_level - 1'b1;
        return slot;
    endfunction

    function automatic void dispatch_slot(logic [3:0] slot);
        run_slot            = slot;
        run_slice           = quantum_of[slot];
        dispatches_of[slot] = dispatches_of[slot] + 1;
    endfunction

    // Applies one command to the predictor state and returns the status
    // the block has to produce for it.
    function automatic status_t predict_status(cmd_t c);
        status_t    s;
        logic [3:0] next_slot;
        s = '0;
        case (c.func)
            FUNC_TICK:
            begin
                elapsed_of[run_slot] = elapsed_of[run_slot] + 1;
                if (run_slice != 0)
                    run_slice = run_slice - 1'b1;
                // Head leaves before the requeue, so a full queue still fits
                if (run_slice == 0 && rq_level != 0)
                begin
                    next_slot = rq_pop();
                    if (run_slot != IDLE_SLOT)
                        rq_push(run_slot);
                    dispatch_slot(next_slot);
                    s.switched = 1'b1;
                end
            end
            FUNC_READY:
            begin
                if (c.task_id == IDLE_SLOT || rq_level >= SLOTS)
                    s.error = 1'b1;
                else
                    rq_push(c.task_id);
            end
            FUNC_QUANTUM:
                quantum_of[c.task_id] = c.quantum_value;
            default:
            begin
                // Leave: no requeue; empty queue falls back to idle
                next_slot = 4'(IDLE_SLOT);
                if (rq_level != 0)
                    next_slot = rq_pop();
                dispatch_slot(next_slot);
                s.switched = 1'b1;
            end
        endcase
        s.running_task   = run_slot;
        s.slice_left     = run_slice;
        s.ready_count    = rq_level;
        s.elapsed_ticks  = elapsed_of[run_slot];
        s.dispatch_count = dispatches_of[run_slot];
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Checker: each status transaction against the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_field(string name, logic [31:0] golden, logic [31:0] actual);
        if (golden !== actual)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, golden, actual);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        status_t golden;
        if (rst_n && status_valid && status_ready)
        begin
            if (pending_status_q.size() == 0)
            begin
                $display("%0t ns: unexpected status transaction 0x%0h", $time, status);
                error_count++;
            end
            else
            begin
                golden = pending_status_q.pop_front();
                report_field("running_task", 32'(golden.running_task), 32'(status.running_task));
                report_field("switched", 32'(golden.switched), 32'(status.switched));
                report_field("slice_left", 32'(golden.slice_left), 32'(status.slice_left));
                report_field("ready_count", 32'(golden.ready_count), 32'(status.ready_count));
                report_field("elapsed_ticks", golden.elapsed_ticks, status.elapsed_ticks);
                report_field("dispatch_count", golden.dispatch_count, status.dispatch_count);
                report_field("error", 32'(golden.error), 32'(status.error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Called at a rising edge. Optionally idles, then holds the command
    // until the handshake; returns at the edge where it was accepted.
    // A typed row replaces the predictor's answer in the expectation queue.
    task automatic send_cmd(cmd_t c, bit typed, status_t golden);
        int unsigned gap;
        status_t     predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predicted = predict_status(c);
        pending_status_q.push_back(typed ? golden : predicted);
    endtask

    // Pause the sender until every outstanding status has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(func_t f, logic [3:0] id, logic [15:0] qv,
                           bit typed, status_t golden);
        dir_row_t r;
        r.cmd    = '{func: f, task_id: id, quantum_value: qv};
        r.typed  = typed;
        r.golden = golden;
        dir_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_t        c;
        int unsigned roll;

        // Predictor reset: slot 1 runs with a quantum of 2, everything else 0
        for (int i = 0; i < SLOTS; i++)
        begin
            rq_slot[i]       = '0;
            quantum_of[i]    = '0;
            elapsed_of[i]    = '0;
            dispatches_of[i] = '0;
        end
        quantum_of[BOOT_SLOT] = 16'(BOOT_QUANTUM);

        // Directed table. Fields of a typed golden status, in order:
        // running_task, switched, slice_left, ready_count, elapsed, dispatches, error
        // Tick right after reset: no dispatch, boot task charged one tick
        add_row(FUNC_TICK, 4'd0, 16'h0000, 1'b1,
                status_t'{4'd1, 1'b0, 16'd0, 5'd0, 32'd1, 32'd0, 1'b0});
        // Idle slot can never be made ready
        add_row(FUNC_READY, 4'd0, 16'h0000, 1'b1,
                status_t'{4'd1, 1'b0, 16'd0, 5'd0, 32'd1, 32'd0, 1'b1});
        // Leave on an empty queue dispatches idle, then idle again
        add_row(FUNC_LEAVE, 4'd0, 16'h0000, 1'b1,
                status_t'{4'd0, 1'b1, 16'd0, 5'd0, 32'd0, 32'd1, 1'b0});
        add_row(FUNC_LEAVE, 4'd0, 16'h0000, 1'b1,
                status_t'{4'd0, 1'b1, 16'd0, 5'd0, 32'd0, 32'd2, 1'b0});
        // Quantum of the running task: slice stays where it is
        add_row(FUNC_QUANTUM, 4'd0, 16'hFFFF, 1'b1,
                status_t'{4'd0, 1'b0, 16'd0, 5'd0, 32'd0, 32'd2, 1'b0});
        // Fill the queue, the last entry a duplicate
        for (int i = 1; i < SLOTS; i++)
            add_row(FUNC_READY, 4'(i), 16'h0000, 1'b0, '0);
        add_row(FUNC_READY, 4'd15, 16'h0000, 1'b0, '0);
        // Enqueue into a full queue is rejected
        add_row(FUNC_READY, 4'd3, 16'h0000, 1'b1,
                status_t'{4'd0, 1'b0, 16'd0, 5'd16, 32'd0, 32'd2, 1'b1});
        // Idle hands over to the head without being requeued
        add_row(FUNC_TICK, 4'd0, 16'h0000, 1'b0, '0);
        add_row(FUNC_READY, 4'd8, 16'h0000, 1'b0, '0);
        // Slice of 2 runs out on a full queue: rotation must still fit
        add_row(FUNC_TICK, 4'd0, 16'h0000, 1'b0, '0);
        add_row(FUNC_TICK, 4'd0, 16'h0000, 1'b0, '0);
        // Leave with a non-empty queue: head dispatched, no requeue
        add_row(FUNC_LEAVE, 4'd0, 16'h0000, 1'b0, '0);

        // Reset held, then released on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].golden);
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                c.task_id       = 4'($urandom_range(SLOTS - 1));
                c.quantum_value = 16'($urandom_range(4));
                roll            = $urandom_range(99);
                // Ticks dominate so slices run out; readies keep the queue busy
                if (roll < 40)
                    c.func = FUNC_TICK;
                else if (roll < 72)
                    c.func = FUNC_READY;
                else if (roll < 87)
                begin
                    c.func = FUNC_QUANTUM;
                    roll   = $urandom_range(9);
                    if (roll == 0)
                        c.quantum_value = 16'hFFFF;
                    else if (roll == 1)
                        c.quantum_value = 16'($urandom());
                end
                else
                    c.func = FUNC_LEAVE;
                // Junk fields on commands that ignore them
                if (c.func == FUNC_TICK || c.func == FUNC_LEAVE || c.func == FUNC_READY)
                    if ($urandom_range(3) == 0)
                        c.quantum_value = 16'($urandom());
                send_cmd(c, 1'b0, '0);
            end
            wait_drained();
        end

        // Let any trailing activity settle before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
